FILE: hw/rtl/duplicate_value_detector_top_defines.svh
// assertion macros used by duplicate_value_detector_top
`ifndef DUPLICATE_VALUE_DETECTOR_TOP_DEFINES_SVH
`define DUPLICATE_VALUE_DETECTOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DVD_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dvd: same-cycle check failed");
`define DVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dvd: next-cycle check failed");
`else
`define DVD_ASSERT(label, clk, rst, ante, cons)
`define DVD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/dvd_pkg.sv
package dvd_pkg;

  localparam int DATA_W = 32;

  // remainder unit: bits of the dividend retired per cycle
  localparam int MOD_STEP = 4;
  localparam int MOD_ITERS = DATA_W / MOD_STEP;
  localparam int MOD_CNT_W = $clog2(MOD_ITERS);

  // set generation tag kept with each bucket row
  localparam int EPOCH_W = 8;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int BIU_W = 9;
  localparam logic [BIU_W-1:0] BIU_RESET = 9'd256;
  localparam logic REG_BUCKETS_IN_USE = 1'b0;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic seen_before;
    logic any_duplicate;
    logic bucket_full;
    logic end_of_set;
  } result_t;

endpackage

FILE: hw/rtl/dvd_ram.sv
module dvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/dvd_mod.sv
module dvd_mod #(
  parameter int DIV_W = 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [dvd_pkg::DATA_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      done,
  output logic [DIV_W-1:0]          rem
);

  logic                         busy;
  logic [dvd_pkg::MOD_CNT_W-1:0] cnt;
  logic [dvd_pkg::DATA_W-1:0]   shf;
  logic [DIV_W-1:0]             div_q;
  logic [DIV_W-1:0]             rem_next;
  logic [DIV_W:0]               part;

  // restoring remainder, several dividend bits per cycle, msb first
  always_comb begin
    part = {1'b0, rem};
    for (int i = 0; i < dvd_pkg::MOD_STEP; i++) begin
      part = {part[DIV_W-1:0], shf[dvd_pkg::DATA_W-1-i]};
      if (part >= {1'b0, div_q}) begin
        part = part - {1'b0, div_q};
      end
    end
    rem_next = part[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == dvd_pkg::MOD_CNT_W'(dvd_pkg::MOD_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shf   <= dividend;
      rem   <= '0;
      div_q <= divisor;
    end else if (busy) begin
      shf <= shf << dvd_pkg::MOD_STEP;
      rem <= rem_next;
    end
  end

endmodule

FILE: hw/rtl/duplicate_value_detector_top.sv
// channel  dir  handshake          payload
// item     in   item_valid/stall   item_t   {value, last}
// result   out  result_valid/stall result_t {seen_before, any_duplicate, bucket_full, end_of_set}
// apb      in   psel/penable       buckets_in_use at byte 0
//
// an item passes through the remainder unit (4 dividend bits a cycle), one bucket row read,
// a scan of one way a cycle through the single value memory read port, a write and an
// output state that waits out result_stall; no new item is taken until it is back in idle
// after reset a clearing pass sweeps every bucket row of the row memory; the same pass
// runs after every 256th set when the set tag wraps, and no item is taken meanwhile
// a result waits in the output register under result_stall while the next item runs
module duplicate_value_detector_top #(
  parameter int BUCKETS = 256,
  parameter int WAYS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  dvd_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output dvd_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dvd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dvd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dvd_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

`include "duplicate_value_detector_top_defines.svh"

  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int ENT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int DIV_W = $clog2(BUCKETS + 1);
  localparam int ROW_W = WAYS + dvd_pkg::EPOCH_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_ROW   = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [dvd_pkg::BIU_W-1:0]   buckets_in_use;
  logic [DIV_W-1:0]            divisor;
  logic [31:0]                 biu_ext;
  logic [dvd_pkg::DATA_W-1:0]  mag;
  logic                        accept;
  logic                        mod_done;
  logic [DIV_W-1:0]            mod_rem;

  logic [dvd_pkg::DATA_W-1:0]  val_q;
  logic                        last_q;
  logic [BKT_W-1:0]            bucket_q;
  logic [WAY_W-1:0]            way_q;
  logic [WAY_W:0]              way_inc;
  logic                        seen_q;
  logic                        free_q;
  logic [WAY_W-1:0]            free_way_q;
  logic                        full_q;
  logic                        dup_flag;
  logic [dvd_pkg::EPOCH_W-1:0] epoch;
  logic [BKT_W-1:0]            clr_q;
  logic                        out_free;

  logic                        row_we;
  logic [BKT_W-1:0]            row_waddr;
  logic [ROW_W-1:0]            row_wdata;
  logic                        row_re;
  logic [ROW_W-1:0]            row_rdata;
  logic [WAYS-1:0]             live_bits;

  logic                        val_we;
  logic [ENT_W-1:0]            val_waddr;
  logic                        val_re;
  logic [ENT_W-1:0]            val_raddr;
  logic [dvd_pkg::DATA_W-1:0]  val_rdata;
  logic [31:0]                 base_ext;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == dvd_pkg::REG_BUCKETS_IN_USE) ?
                  dvd_pkg::APB_DATA_W'(buckets_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      buckets_in_use <= dvd_pkg::BIU_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == dvd_pkg::REG_BUCKETS_IN_USE) begin
      buckets_in_use <= pwdata[dvd_pkg::BIU_W-1:0];
    end
  end

  // zero reads as one, anything above the bucket count is clamped
  assign biu_ext = 32'(buckets_in_use);
  assign divisor = (buckets_in_use == '0) ? DIV_W'(1) :
                   (biu_ext > 32'(BUCKETS)) ? DIV_W'(BUCKETS) : DIV_W'(biu_ext);

  assign mag = item.value[dvd_pkg::DATA_W-1] ? (32'd0 - $unsigned(item.value)) :
                                               $unsigned(item.value);

  assign item_stall = (state != S_IDLE);
  assign accept = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;

  dvd_mod #(.DIV_W(DIV_W)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (mag),
    .divisor  (divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // bucket rows: per-way valid bits tagged with the set generation
  assign live_bits = (row_rdata[ROW_W-1:WAYS] == epoch) ? row_rdata[WAYS-1:0] : '0;

  always_comb begin
    row_we    = 1'b0;
    row_waddr = bucket_q;
    row_wdata = {epoch, live_bits | (WAYS'(1) << free_way_q)};
    if (state == S_CLEAR) begin
      row_we    = 1'b1;
      row_waddr = clr_q;
      row_wdata = '0;
    end else if (state == S_WRITE && !seen_q && free_q) begin
      row_we = 1'b1;
    end
  end

  assign row_re = (state == S_ROW);

  dvd_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (bucket_q),
    .rdata (row_rdata)
  );

  // stored values, one way a cycle
  assign base_ext = 32'(bucket_q) * WAYS;
  assign way_inc = {1'b0, way_q} + (WAY_W + 1)'(1);
  assign val_we = (state == S_WRITE) && !seen_q && free_q;
  assign val_waddr = ENT_W'(base_ext + 32'(free_way_q));
  assign val_re = (state == S_ROW) ||
                  ((state == S_SCAN) && (way_q != WAY_W'(WAYS - 1)));
  assign val_raddr = (state == S_ROW) ? ENT_W'(base_ext) :
                                        ENT_W'(base_ext + 32'(way_inc));

  dvd_ram #(.WIDTH(dvd_pkg::DATA_W), .DEPTH(ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_q),
    .re    (val_re),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_MOD;
      end
      S_CLEAR: begin
        if (clr_q == BKT_W'(BUCKETS - 1)) state_next = S_IDLE;
      end
      S_MOD: begin
        if (mod_done) state_next = S_ROW;
      end
      S_ROW: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (way_q == WAY_W'(WAYS - 1)) state_next = S_WRITE;
      end
      S_WRITE: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          if (last_q && epoch == {dvd_pkg::EPOCH_W{1'b1}}) state_next = S_CLEAR;
          else state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_q        <= '0;
      epoch        <= '0;
      dup_flag     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (state == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state == S_WRITE && seen_q) begin
        dup_flag <= 1'b1;
      end
      if (state == S_OUT && out_free && last_q) begin
        dup_flag <= 1'b0;
        epoch    <= epoch + 1'b1;
        clr_q    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_q  <= $unsigned(item.value);
      last_q <= item.last;
    end
    if (state == S_MOD && mod_done) begin
      bucket_q <= mod_rem[BKT_W-1:0];
    end
    if (state == S_ROW) begin
      way_q  <= '0;
      seen_q <= 1'b0;
      free_q <= 1'b0;
      full_q <= 1'b0;
    end
    if (state == S_SCAN) begin
      way_q <= way_inc[WAY_W-1:0];
      if (live_bits[way_q]) begin
        if (val_rdata == val_q) seen_q <= 1'b1;
      end else if (!free_q) begin
        free_q     <= 1'b1;
        free_way_q <= way_q;
      end
    end
    if (state == S_WRITE) begin
      full_q <= !seen_q && !free_q;
    end
    if (state == S_OUT && out_free) begin
      result.seen_before   <= seen_q;
      result.any_duplicate <= dup_flag;
      result.bucket_full   <= full_q;
      result.end_of_set    <= last_q;
    end
  end

  `DVD_ASSERT_NEXT(a_accept_starts_mod, clk, rst, accept, state == S_MOD)
  `DVD_ASSERT(a_rem_below_divisor, clk, rst, mod_done, mod_rem < divisor)
  `DVD_ASSERT(a_full_excludes_seen, clk, rst, result_valid,
              !(result.bucket_full && result.seen_before))
  `DVD_ASSERT(a_seen_sets_flag, clk, rst, result_valid && result.seen_before,
              result.any_duplicate)

endmodule

FILE: sim/dvd_check.sv
`timescale 1ns / 1ps
module dvd_check #(
  parameter int BUCKETS = 256,
  parameter int WAYS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  logic                           item_stall,
  input  dvd_pkg::item_t                 item,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  dvd_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [dvd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dvd_pkg::APB_DATA_W-1:0] pwdata,
  output int                             errors,
  output int                             outstanding
);

  localparam int SLOTS = BUCKETS * WAYS;
  localparam logic [dvd_pkg::APB_ADDR_W-1:0] BIU_ADDR =
    dvd_pkg::APB_ADDR_W'(4 * dvd_pkg::REG_BUCKETS_IN_USE);

  logic [dvd_pkg::DATA_W-1:0] slot_value [SLOTS];
  bit                         slot_used [SLOTS];
  bit                         dup_sticky;
  logic [dvd_pkg::BIU_W-1:0]  divisor_reg;
  dvd_pkg::result_t           answers [$];

  function automatic void clear_set();
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    dup_sticky = 1'b0;
  endfunction

  // look the value up in its bucket row, store it in the first free way if new
  function automatic dvd_pkg::result_t probe_set(logic [dvd_pkg::DATA_W-1:0] v,
                                                 logic last_in);
    logic [dvd_pkg::DATA_W-1:0] mag;
    int unsigned div;
    int unsigned row;
    int free_way;
    dvd_pkg::result_t r;
    mag = v[dvd_pkg::DATA_W-1] ? (32'd0 - v) : v;
    div = 32'(divisor_reg);
    if (div == 0) begin
      div = 1;
    end else if (div > BUCKETS) begin
      div = BUCKETS;
    end
    row = (mag % div) * WAYS;
    r = '0;
    free_way = WAYS;
    for (int w = 0; w < WAYS; w++) begin
      if (slot_used[row + w]) begin
        if (slot_value[row + w] == v) r.seen_before = 1'b1;
      end else if (free_way == WAYS) begin
        free_way = w;
      end
    end
    if (r.seen_before) begin
      dup_sticky = 1'b1;
    end else if (free_way < WAYS) begin
      slot_value[row + free_way] = v;
      slot_used[row + free_way] = 1'b1;
    end else begin
      r.bucket_full = 1'b1;
    end
    r.any_duplicate = dup_sticky;
    r.end_of_set = last_in;
    if (last_in) clear_set();
    return r;
  endfunction

  function automatic int field_bad(string name, logic want, logic got);
    if (want !== got) begin
      $display("%0t: %s expected %b actual %b", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    dvd_pkg::result_t want;
    int nbad;
    int delta;
    if (rst) begin
      divisor_reg = dvd_pkg::BIU_RESET;
      clear_set();
      answers.delete();
      errors <= 0;
      outstanding <= 0;
    end else begin
      nbad = 0;
      delta = 0;
      // compare before predicting: a request never returns in the cycle it enters
      if (result_valid && !result_stall) begin
        if (answers.size() == 0) begin
          $display("%0t: result expected none actual %b", $time, result);
          nbad = 1;
        end else begin
          want = answers.pop_front();
          delta = delta - 1;
          nbad += field_bad("seen_before", want.seen_before, result.seen_before);
          nbad += field_bad("any_duplicate", want.any_duplicate, result.any_duplicate);
          nbad += field_bad("bucket_full", want.bucket_full, result.bucket_full);
          nbad += field_bad("end_of_set", want.end_of_set, result.end_of_set);
        end
      end
      if (item_valid && !item_stall) begin
        answers.push_back(probe_set(item.value, item.last));
        delta = delta + 1;
      end
      if (psel && penable && pwrite && pready && paddr == BIU_ADDR)
        divisor_reg = pwdata[dvd_pkg::BIU_W-1:0];
      if (nbad != 0) errors <= errors + nbad;
      outstanding <= outstanding + delta;
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int BUCKETS = 256;
  localparam int WAYS = 4;
  localparam int LATENCY = WAYS + 12;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES = 13;
  localparam logic [dvd_pkg::APB_ADDR_W-1:0] BIU_ADDR =
    dvd_pkg::APB_ADDR_W'(4 * dvd_pkg::REG_BUCKETS_IN_USE);

  logic                           clk;
  logic                           rst;
  logic                           item_valid;
  logic                           item_stall;
  dvd_pkg::item_t                 item;
  logic                           result_valid;
  logic                           result_stall;
  dvd_pkg::result_t               result;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [dvd_pkg::APB_ADDR_W-1:0] paddr;
  logic [dvd_pkg::APB_DATA_W-1:0] pwdata;
  logic [dvd_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  int          errors;
  int          outstanding;
  int unsigned cycles;
  int unsigned div_now;
  int          burst_left;
  int          set_left;
  bit          hold_req;
  bit          hold_done;
  logic [dvd_pkg::DATA_W-1:0] set_history [$];

  int unsigned phase_biu [PHASES] = '{1, 0, 511, 2, 3, 256, 257, 7, 16, 100, 255, 0, 0};

  duplicate_value_detector_top #(.BUCKETS(BUCKETS), .WAYS(WAYS)) uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dvd_check #(.BUCKETS(BUCKETS), .WAYS(WAYS)) watcher (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: segments of different stall patterns plus one long hold-off
  initial begin : drain_side
    int mode;
    int seg;
    bit stall;
    forever begin
      mode = $urandom_range(0, 3);
      seg = $urandom_range(20, 300);
      repeat (seg) begin
        if (hold_req && !hold_done) begin
          hold_done = 1'b1;
          result_stall <= 1'b1;
          repeat (600) @(posedge clk);
        end else begin
          case (mode)
            0: stall = 1'b0;
            1: stall = ($urandom_range(0, 3) == 0);
            2: stall = ($urandom_range(0, 3) != 0);
            default: stall = ((cycles % 11) < 6);
          endcase
          result_stall <= stall;
          @(posedge clk);
        end
      end
    end
  end

  task automatic pause(int n);
    item_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(logic [dvd_pkg::DATA_W-1:0] v, logic l);
    item_valid <= 1'b1;
    item <= {v, l};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 24));
    end
  endtask

  task automatic write_reg(logic [dvd_pkg::APB_ADDR_W-1:0] addr,
                           logic [dvd_pkg::APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait until every request has answered and any clearing pass is over, then write the new bucket count
  task automatic set_divisor(int unsigned biu);
    logic [dvd_pkg::APB_DATA_W-1:0] wdata;
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (BUCKETS + LATENCY) @(posedge clk);
    wdata = $urandom();
    wdata[dvd_pkg::BIU_W-1:0] = dvd_pkg::BIU_W'(biu);
    write_reg(BIU_ADDR, wdata);
    div_now = (biu == 0) ? 1 : (biu > BUCKETS) ? BUCKETS : biu;
  endtask

  // mix of repeats, same-bucket colliders, corner values and noise
  function automatic logic [dvd_pkg::DATA_W-1:0] pick_value();
    int r;
    int unsigned k;
    int unsigned b;
    logic [dvd_pkg::DATA_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 30 && set_history.size() > 0) begin
      v = set_history[$urandom_range(0, set_history.size() - 1)];
    end else if (r < 60) begin
      k = $urandom_range(0, 7);
      b = $urandom_range(0, 3) % div_now;
      v = k * div_now + b;
      if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
    end else if (r < 70) begin
      case ($urandom_range(0, 4))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'hffff_ffff;
        3: v = 32'h0000_0000;
        default: v = 32'h8000_0001;
      endcase
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  initial begin : stimulus
    int r;
    int unsigned biu;
    logic [dvd_pkg::DATA_W-1:0] v;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    div_now = BUCKETS;
    burst_left = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset divisor of 256: bucket zero filled to its last way, then overflowed
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h0000_0100, 1'b0);
    send_item(32'hffff_fe00, 1'b0);
    send_item(32'h0000_0300, 1'b0);
    send_item(32'h0000_0300, 1'b0);
    send_item(32'hffff_fe00, 1'b0);
    send_item(32'hffff_ff00, 1'b0);
    send_item(32'h5555_5555, 1'b1);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'haaaa_aaaa, 1'b1);
    send_item(32'hffff_ffff, 1'b1);

    // phases may stop mid-set, so the divisor also changes inside a set
    set_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 2) begin
        biu = $urandom_range(1, BUCKETS);
      end else if (p == PHASES - 1) begin
        biu = $urandom_range(0, 511);
      end else begin
        biu = phase_biu[p];
      end
      set_divisor(biu);
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (set_left == 0) begin
          r = $urandom_range(0, 99);
          set_left = (r < 10) ? 1 : (r < 85) ? $urandom_range(2, 10) : $urandom_range(11, 40);
          set_history.delete();
        end
        v = pick_value();
        set_history.push_back(v);
        send_item(v, set_left == 1);
        set_left = set_left - 1;
      end
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/dvd_pkg.sv
hw/rtl/dvd_ram.sv
hw/rtl/dvd_mod.sv
hw/rtl/duplicate_value_detector_top.sv
sim/dvd_check.sv
sim/tb.sv
